FILE: rtl/core/pcv_pkg.sv
`default_nettype none
package pcv_pkg;

    localparam int PCV_MAX_WIDTH  = 4096;
    localparam int PCV_MAX_HEIGHT = 4096;
    localparam int PCV_QDEPTH     = 2;
    localparam int PCV_NUM_W      = 27;

    localparam logic [12:0] PCV_RST_SRC_W = 13'd1280;
    localparam logic [12:0] PCV_RST_SRC_H = 13'd720;
    localparam logic [12:0] PCV_RST_DST_W = 13'd320;
    localparam logic [12:0] PCV_RST_DST_H = 13'd240;

    localparam logic [1:0] REG_SRC_W = 2'd0;
    localparam logic [1:0] REG_SRC_H = 2'd1;
    localparam logic [1:0] REG_DST_W = 2'd2;
    localparam logic [1:0] REG_DST_H = 2'd3;

    typedef struct packed {
        logic [7:0] chroma;
        logic [7:0] luma_left;
        logic [7:0] luma_right;
        logic       frame_start;
    } item_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] out_col;
        logic [11:0] out_row;
        logic        last;
    } result_t;

    // effective frame geometry after clamping
    typedef struct packed {
        logic [12:0] w_src;
        logic [12:0] h_src;
        logic [12:0] w_dst;
        logic [12:0] h_dst;
    } geom_t;

    typedef struct packed {
        logic [7:0]  v;
        logic [7:0]  u;
        logic [7:0]  y00;
        logic [7:0]  y01;
        logic [7:0]  y10;
        logic [7:0]  y11;
        logic [12:0] row;
        logic [12:0] col2;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_CHK,
        B_CMP,
        B_EMIT
    } back_state_t;

    function automatic logic [7:0] to_byte(input logic signed [19:0] t);
        logic [7:0] r;
        if (t < 0)
        begin
            r = 8'd0;
        end
        else if (t[19:16] != 4'd0)
        begin
            r = 8'd255;
        end
        else
        begin
            r = t[15:8];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pcv_queue.sv
`default_nettype none
module pcv_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  q_full,
    input  wire logic             rd,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  q_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wp_reg, rp_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_wr, do_rd;

    assign q_full  = (cnt_reg == CW'(DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/pcv_front.sv
`default_nettype none
module pcv_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pcv_pkg::geom_t geom,
    input  wire logic           push,
    input  wire pcv_pkg::item_t item,
    output logic                full,
    output logic                job_wr,
    output pcv_pkg::job_t       job,
    input  wire logic           job_full
);
    import pcv_pkg::*;

    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [23:0]   store_mem [DEPTH];
    logic [23:0]   rd_reg;
    logic [AW-1:0] col_reg, col_cur;
    logic [11:0]   row_reg, row_cur;
    logic          stage_valid_reg;
    logic [7:0]    v_reg, yl_reg, yr_reg;
    logic [AW-1:0] scol_reg;
    logic [11:0]   srow_reg;
    logic          accept, in_range, odd, wrap;
    logic [AW:0]   col_inc;
    logic [11:0]   half;
    logic [12:0]   row_inc;

    assign full   = stage_valid_reg && job_full;
    assign accept = push && !full;
    assign job_wr = stage_valid_reg && !job_full;

    always_comb
    begin
        col_cur  = item.frame_start ? '0 : col_reg;
        row_cur  = item.frame_start ? '0 : row_reg;
        half     = geom.w_src[12:1];
        in_range = (12'(col_cur) < half);
        odd      = row_cur[0];
        col_inc  = {1'b0, col_cur} + 1'b1;
        wrap     = (13'(col_inc) >= {1'b0, half});
        row_inc  = {1'b0, row_cur} + (wrap ? 13'd1 : 13'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg         <= wrap ? '0 : col_inc[AW-1:0];
                row_reg         <= (row_inc >= geom.h_src) ? '0 : row_inc[11:0];
                stage_valid_reg <= odd && in_range;
            end
            else if (job_wr)
            begin
                stage_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg    <= item.chroma;
            yl_reg   <= item.luma_left;
            yr_reg   <= item.luma_right;
            scol_reg <= col_cur;
            srow_reg <= row_cur;
        end
        if (accept && in_range && !odd)
        begin
            store_mem[col_cur] <= {item.chroma, item.luma_left, item.luma_right};
        end
        if (accept && in_range && odd)
        begin
            rd_reg <= store_mem[col_cur];
        end
    end

    always_comb
    begin
        job.v    = v_reg;
        job.u    = rd_reg[23:16];
        job.y00  = rd_reg[15:8];
        job.y01  = rd_reg[7:0];
        job.y10  = yl_reg;
        job.y11  = yr_reg;
        job.row  = {1'b0, srow_reg};
        job.col2 = 13'({scol_reg, 1'b0});
    end
endmodule
`default_nettype wire

FILE: rtl/core/pcv_back.sv
`default_nettype none
module pcv_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pcv_pkg::geom_t geom,
    input  wire pcv_pkg::job_t  job,
    input  wire logic           job_empty,
    output logic                job_rd,
    output logic                res_wr,
    output pcv_pkg::result_t    res,
    input  wire logic           res_full
);
    import pcv_pkg::*;

    back_state_t state_reg, state_next;
    job_t        job_reg;
    logic [1:0]  pick_reg, pix_reg;
    logic [PCV_NUM_W-1:0] lim_reg, num_reg;
    logic [12:0] rem_reg;
    logic [4:0]  cnt_reg;
    logic [25:0] chk_reg;
    logic        over_reg;
    logic [3:0]  hit_reg;
    logic [11:0] d_reg [4];

    logic [12:0] s_sel, sn, dn;
    logic [25:0] mul1, mul2;
    logic [13:0] rem_sh;
    logic        qbit, last_step, cmp_hit;
    logic [3:0]  pix_hit;
    logic        hit_now, later;
    logic [7:0]  y;
    logic signed [8:0]  cb, cr;
    logic signed [19:0] y256, r_sum, g_sum, b_sum;

    always_comb
    begin
        unique case (pick_reg)
            2'd0:    s_sel = job_reg.row - 13'd1;
            2'd1:    s_sel = job_reg.row;
            2'd2:    s_sel = job_reg.col2;
            default: s_sel = job_reg.col2 + 13'd1;
        endcase
        sn        = pick_reg[1] ? geom.w_src : geom.h_src;
        dn        = pick_reg[1] ? geom.w_dst : geom.h_dst;
        mul1      = s_sel * dn;
        mul2      = num_reg[12:0] * sn;
        rem_sh    = {rem_reg, num_reg[PCV_NUM_W-1]};
        qbit      = (rem_sh >= {1'b0, sn});
        last_step = (cnt_reg == 5'(PCV_NUM_W - 1));
        cmp_hit   = !over_reg && ({1'b0, chk_reg} < lim_reg);
    end

    // pixel order: even row left, even row right, odd row left, odd row right
    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            pix_hit[p] = hit_reg[p / 2] && hit_reg[2 + (p % 2)];
        end
        hit_now = pix_hit[pix_reg];
        later   = 1'b0;
        for (int p = 0; p < 4; p++)
        begin
            if (2'(p) > pix_reg)
            begin
                later = later | pix_hit[p];
            end
        end
        unique case (pix_reg)
            2'd0:    y = job_reg.y00;
            2'd1:    y = job_reg.y01;
            2'd2:    y = job_reg.y10;
            default: y = job_reg.y11;
        endcase
        cb    = $signed({1'b0, job_reg.u}) - 9'sd128;
        cr    = $signed({1'b0, job_reg.v}) - 9'sd128;
        y256  = $signed({4'd0, y, 8'd0});
        r_sum = y256 + 20'sd359 * 20'(cr) + 20'sd128;
        g_sum = y256 - 20'sd88 * 20'(cb) - 20'sd183 * 20'(cr) + 20'sd128;
        b_sum = y256 + 20'sd454 * 20'(cb) + 20'sd128;
        res.red     = to_byte(r_sum);
        res.green   = to_byte(g_sum);
        res.blue    = to_byte(b_sum);
        res.out_row = d_reg[{1'b0, pix_reg[1]}];
        res.out_col = d_reg[{1'b1, pix_reg[0]}];
        res.last    = !later;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                if (dn == '0)
                begin
                    state_next = (pick_reg == 2'd3) ? B_EMIT : B_MUL;
                end
                else
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (last_step)
                begin
                    state_next = B_CHK;
                end
            end
            B_CHK:
            begin
                state_next = B_CMP;
            end
            B_CMP:
            begin
                state_next = (pick_reg == 2'd3) ? B_EMIT : B_MUL;
            end
            B_EMIT:
            begin
                if ((!hit_now || !res_full) && pix_reg == 2'd3)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        job_rd = (state_reg == B_IDLE) && !job_empty;
        res_wr = (state_reg == B_EMIT) && hit_now && !res_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                job_reg  <= job;
                pick_reg <= 2'd0;
                pix_reg  <= 2'd0;
            end
            B_MUL:
            begin
                // limit is (s+1)*dn, dividend rounds s*dn up
                lim_reg <= {1'b0, mul1} + PCV_NUM_W'(dn);
                num_reg <= {1'b0, mul1} + PCV_NUM_W'(sn) - 1'b1;
                rem_reg <= '0;
                cnt_reg <= '0;
                if (dn == '0)
                begin
                    hit_reg[pick_reg] <= 1'b0;
                    pick_reg          <= pick_reg + 1'b1;
                end
            end
            B_DIV:
            begin
                rem_reg <= qbit ? 13'(rem_sh - {1'b0, sn}) : rem_sh[12:0];
                num_reg <= {num_reg[PCV_NUM_W-2:0], qbit};
                cnt_reg <= cnt_reg + 1'b1;
            end
            B_CHK:
            begin
                chk_reg         <= mul2;
                over_reg        <= (num_reg >= PCV_NUM_W'(dn));
                d_reg[pick_reg] <= num_reg[11:0];
            end
            B_CMP:
            begin
                hit_reg[pick_reg] <= cmp_hit;
                pick_reg          <= pick_reg + 1'b1;
            end
            B_EMIT:
            begin
                if (!hit_now || !res_full)
                begin
                    pix_reg <= pix_reg + 1'b1;
                end
            end
            default:
            begin
                pix_reg <= 2'd0;
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/core/packed_yuv420_decimating_rgb_converter.sv
`default_nettype none
// Packed 4:2:0 to RGB888 converter with nearest-neighbour decimation.
// Push triplets (chroma, left luma, right luma) in raster order; even rows
// are kept in a line store, and each odd-row triplet yields up to four RGB
// words with destination coordinates, popped in order even-left, even-right,
// odd-left, odd-right. An even-row triplet only fills the line store. An odd-row
// triplet goes to the back end, which takes the job, runs four mappings from
// source to destination, each around a 27-step serial divider, then steps
// through the four candidate pixels, stalling on a kept one while the output
// is full; a two-entry queue lets the front keep accepting meanwhile.
// The line store holds garbage until the first even row is written, so start
// each frame with frame_start. Configure only while idle.
module packed_yuv420_decimating_rgb_converter #(
    parameter int MAX_WIDTH = pcv_pkg::PCV_MAX_WIDTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire pcv_pkg::item_t   item,
    output logic                  full,
    output logic                  empty,
    input  wire logic             pop,
    output pcv_pkg::result_t      result,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import pcv_pkg::*;

    localparam logic [13:0] W_CAP = 14'((MAX_WIDTH / 2) * 2);
    localparam logic [12:0] H_CAP = 13'((PCV_MAX_HEIGHT / 2) * 2);

    logic [12:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [12:0] w_even, h_even;
    geom_t       geom;
    job_t        job_in, job_out;
    logic        job_wr, job_rd, job_full, job_empty;
    result_t     res;
    logic        res_wr, res_full;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= PCV_RST_SRC_W;
            src_h_reg <= PCV_RST_SRC_H;
            dst_w_reg <= PCV_RST_DST_W;
            dst_h_reg <= PCV_RST_DST_H;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_SRC_W: src_w_reg <= pwdata[12:0];
                REG_SRC_H: src_h_reg <= pwdata[12:0];
                REG_DST_W: dst_w_reg <= pwdata[12:0];
                REG_DST_H: dst_h_reg <= pwdata[12:0];
                default:   src_w_reg <= src_w_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SRC_W: prdata = {19'd0, src_w_reg};
            REG_SRC_H: prdata = {19'd0, src_h_reg};
            REG_DST_W: prdata = {19'd0, dst_w_reg};
            REG_DST_H: prdata = {19'd0, dst_h_reg};
            default:   prdata = '0;
        endcase
    end

    // clamp to even, at least 2, at most the cap; targets never exceed sources
    always_comb
    begin
        w_even = {src_w_reg[12:1], 1'b0};
        h_even = {src_h_reg[12:1], 1'b0};
        if (w_even < 13'd2)
        begin
            w_even = 13'd2;
        end
        if ({1'b0, w_even} > W_CAP)
        begin
            w_even = W_CAP[12:0];
        end
        if (h_even < 13'd2)
        begin
            h_even = 13'd2;
        end
        if (h_even > H_CAP)
        begin
            h_even = H_CAP;
        end
        geom.w_src = w_even;
        geom.h_src = h_even;
        geom.w_dst = (dst_w_reg > w_even) ? w_even : dst_w_reg;
        geom.h_dst = (dst_h_reg > h_even) ? h_even : dst_h_reg;
    end

    pcv_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .geom    (geom),
        .push    (push),
        .item    (item),
        .full    (full),
        .job_wr  (job_wr),
        .job     (job_in),
        .job_full(job_full)
    );

    pcv_queue #(
        .WIDTH($bits(job_t)),
        .DEPTH(PCV_QDEPTH)
    ) u_job_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (job_wr),
        .wr_data(job_in),
        .q_full (job_full),
        .rd     (job_rd),
        .rd_data(job_out),
        .q_empty(job_empty)
    );

    pcv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .geom     (geom),
        .job      (job_out),
        .job_empty(job_empty),
        .job_rd   (job_rd),
        .res_wr   (res_wr),
        .res      (res),
        .res_full (res_full)
    );

    pcv_queue #(
        .WIDTH($bits(result_t)),
        .DEPTH(PCV_QDEPTH)
    ) u_res_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (res_wr),
        .wr_data(res),
        .q_full (res_full),
        .rd     (pop),
        .rd_data(result),
        .q_empty(empty)
    );
endmodule
`default_nettype wire

FILE: rtl/core/pcv_checker.sv
`default_nettype none
module pcv_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             push,
    input wire logic             full,
    input wire logic             empty,
    input wire logic             pop,
    input wire pcv_pkg::result_t result,
    input wire logic             pready
);
    import pcv_pkg::*;

    a_pready: assert property (@(posedge clk) pready)
        else $error("pready dropped");

    a_rst_empty: assert property (@(posedge clk) !rst_n |-> empty && !full)
        else $error("queue state not cleared by reset");

    // full rises only right after an input word was taken
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("full rose without an accepted word");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty && $stable(result))
        else $error("waiting word changed");
endmodule

bind packed_yuv420_decimating_rgb_converter pcv_checker u_pcv_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .result(result),
    .pready(pready)
);
`default_nettype wire
